// File: hdl/arpc_pkg.sv
package arpc_pkg;

	localparam int PORTS = 16;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_LEARN  = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_MISS      = 3'd1;
	localparam logic [2:0] ST_ADDED     = 3'd2;
	localparam logic [2:0] ST_UNCHANGED = 3'd3;
	localparam logic [2:0] ST_REPLACED  = 3'd4;
	localparam logic [2:0] ST_DELETED   = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;
	localparam logic [2:0] ST_CLEARED   = 3'd7;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [3:0]  port;
	} entry_t;

	typedef struct packed {
		logic   wr_en;
		logic   set_valid;
		logic   clr_valid;
		logic   clr_all;
		entry_t ent;
	} wr_cmd_t;

	typedef struct packed {
		logic        found;
		logic [47:0] mac;
		logic [3:0]  port;
		logic [2:0]  status;
	} result_t;

endpackage

// File: hdl/arpc_store.sv
module arpc_store #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output logic                rd_valid_s1,
	output arpc_pkg::entry_t    rd_ent_s1,
	input  arpc_pkg::wr_cmd_t   wr,
	input  logic [IDX_W-1:0]    wr_addr
);

	arpc_pkg::entry_t       mem [ENTRIES];
	logic [ENTRIES-1:0]     valid_q;

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr_addr] <= wr.ent;
		end
		if (rd_en) begin
			rd_ent_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr.clr_all) begin
				valid_q <= '0;
			end else if (wr.set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (wr.clr_valid) begin
				valid_q[wr_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

endmodule

// File: hdl/arpc_ctrl.sv
module arpc_ctrl #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [31:0]         ip_address,
	input  logic [47:0]         mac_address,
	input  logic [3:0]          port_index,
	input  logic                res_ready,
	output logic                res_vld,
	output arpc_pkg::result_t   res,
	output logic                rd_en,
	output logic [IDX_W-1:0]    rd_addr,
	input  logic                rd_valid_s1,
	input  arpc_pkg::entry_t    rd_ent_s1,
	output arpc_pkg::wr_cmd_t   wr,
	output logic [IDX_W-1:0]    wr_addr
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	logic [1:0]        state_q;
	logic [1:0]        mode_q;
	logic [31:0]       key_q;
	logic [47:0]       mac_q;
	logic [3:0]        port_q;
	logic              bad_port_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic              issue_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [47:0]       hit_mac_q;
	logic [3:0]        hit_port_q;
	logic              free_vld_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              in_fire;
	logic              match;
	logic              go;
	arpc_pkg::result_t res_c;
	arpc_pkg::wr_cmd_t wr_c;
	logic [IDX_W-1:0]  wr_addr_c;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign rd_en    = (state_q == S_SCAN) && issue_q;
	assign rd_addr  = rd_addr_q;
	// shared key comparator
	assign match    = cmp_vld_s1 && rd_valid_s1 && (rd_ent_s1.ip == key_q);
	assign go       = (state_q == S_DECIDE) && res_ready;
	assign res_vld  = (state_q == S_DECIDE);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode;
			key_q <= ip_address;
			mac_q <= mac_address;
			port_q <= port_index;
			bad_port_q <= (9'(port_index) >= 9'(arpc_pkg::PORTS));
		end
		if (match) begin
			hit_idx_q <= cmp_idx_s1;
			hit_mac_q <= rd_ent_s1.mac;
			hit_port_q <= rd_ent_s1.port;
		end
		if (cmp_vld_s1 && !rd_valid_s1 && !free_vld_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_addr_q <= '0;
			issue_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_vld_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						hit_q <= 1'b0;
						free_vld_q <= 1'b0;
						rd_addr_q <= '0;
						issue_q <= 1'b1;
						if (mode == arpc_pkg::MODE_CLEAR ||
						    (mode == arpc_pkg::MODE_LEARN &&
						     9'(port_index) >= 9'(arpc_pkg::PORTS))) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						if (rd_addr_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + IDX_W'(1);
						end
					end
					if (cmp_vld_s1 && !rd_valid_s1) begin
						free_vld_q <= 1'b1;
					end
					if (match) begin
						hit_q <= 1'b1;
						state_q <= S_DECIDE;
					end else if (cmp_vld_s1 && cmp_idx_s1 == LAST) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_c = '0;
		res_c.status = arpc_pkg::ST_MISS;
		wr_c = '0;
		wr_c.ent.ip = key_q;
		wr_c.ent.mac = mac_q;
		wr_c.ent.port = port_q;
		wr_addr_c = hit_idx_q;
		case (mode_q)
			arpc_pkg::MODE_LOOKUP: begin
				if (hit_q) begin
					res_c.found = 1'b1;
					res_c.mac = hit_mac_q;
					res_c.port = hit_port_q;
					res_c.status = arpc_pkg::ST_HIT;
				end
			end
			arpc_pkg::MODE_LEARN: begin
				if (bad_port_q) begin
					res_c.status = arpc_pkg::ST_MISS;
				end else if (hit_q) begin
					if (hit_mac_q == mac_q && hit_port_q == port_q) begin
						res_c.status = arpc_pkg::ST_UNCHANGED;
					end else begin
						wr_c.wr_en = 1'b1;
						res_c.status = arpc_pkg::ST_REPLACED;
					end
				end else if (free_vld_q) begin
					wr_c.wr_en = 1'b1;
					wr_c.set_valid = 1'b1;
					wr_addr_c = free_idx_q;
					res_c.status = arpc_pkg::ST_ADDED;
				end else begin
					res_c.status = arpc_pkg::ST_FULL;
				end
			end
			arpc_pkg::MODE_DELETE: begin
				if (hit_q) begin
					wr_c.clr_valid = 1'b1;
					res_c.status = arpc_pkg::ST_DELETED;
				end
			end
			arpc_pkg::MODE_CLEAR: begin
				wr_c.clr_all = 1'b1;
				res_c.status = arpc_pkg::ST_CLEARED;
			end
			default: begin
				res_c.status = arpc_pkg::ST_MISS;
			end
		endcase
	end

	assign res     = res_c;
	assign wr      = go ? wr_c : '0;
	assign wr_addr = wr_addr_c;

	a_hit_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && match) |=> (state_q == S_DECIDE && hit_q))
		else $error("key match did not end the scan");

	a_add_free_only: assert property (@(posedge clk) disable iff (!arst_n)
		wr.set_valid |-> (!hit_q && free_vld_q && wr_addr == free_idx_q))
		else $error("add to a slot that was not free");

	a_found_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.found) |-> (hit_q && mode_q == arpc_pkg::MODE_LOOKUP))
		else $error("found without a lookup hit");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({wr.wr_en, wr.clr_valid, wr.clr_all}) <= 1)
		else $error("conflicting table updates");

endmodule

// File: hdl/arp_cache_table.sv
// ARP cache with ENTRIES slots keyed by IPv4 address. Each request carries one
// mode (lookup, learn, delete, clear) and yields exactly one result. Lookup,
// learn and delete walk the table one slot per cycle through a single key
// comparator on a registered memory read, stopping early on a hit. Clear and
// a learn with an out-of-range port skip the walk and go straight to the result.
// in_stall stays high while a request is in work; a finished result waits in
// the output register, so a new request may be taken before it is drained.
// Learn writes the lowest free slot when the key is absent, or reports table
// full when none is free.
module arp_cache_table #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] ip_address,
	input  logic [47:0] mac_address,
	input  logic [3:0]  port_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [47:0] found_mac,
	output logic [3:0]  found_port,
	output logic [2:0]  status
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic                res_ready;
	logic                res_vld;
	arpc_pkg::result_t   res;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                rd_valid_s1;
	arpc_pkg::entry_t    rd_ent_s1;
	arpc_pkg::wr_cmd_t   wr;
	logic [IDX_W-1:0]    wr_addr;
	logic                out_valid_q;
	arpc_pkg::result_t   out_q;

	arpc_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.ip_address  (ip_address),
		.mac_address (mac_address),
		.port_index  (port_index),
		.res_ready   (res_ready),
		.res_vld     (res_vld),
		.res         (res),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_valid_s1 (rd_valid_s1),
		.rd_ent_s1   (rd_ent_s1),
		.wr          (wr),
		.wr_addr     (wr_addr)
	);

	arpc_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_valid_s1 (rd_valid_s1),
		.rd_ent_s1   (rd_ent_s1),
		.wr          (wr),
		.wr_addr     (wr_addr)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (res_vld && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_vld;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign found_mac  = out_q.mac;
	assign found_port = out_q.port;
	assign status     = out_q.status;

endmodule

// File: bench/arp_cache_table_tb.sv
module arp_cache_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CACHE_SLOTS    = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTED    = 50;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  mode        = arpc_pkg::MODE_LOOKUP;
	logic [31:0] ip_address  = '0;
	logic [47:0] mac_address = '0;
	logic [3:0]  port_index  = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        found;
	logic [47:0] found_mac;
	logic [3:0]  found_port;
	logic [2:0]  status;

	// predicted cache contents
	bit          tbl_valid [CACHE_SLOTS];
	logic [31:0] tbl_ip    [CACHE_SLOTS];
	logic [47:0] tbl_mac   [CACHE_SLOTS];
	logic [3:0]  tbl_port  [CACHE_SLOTS];

	arpc_pkg::result_t pending_results[$];
	logic [31:0]       key_pool[$];

	int n_requests  = 0;
	int n_results   = 0;
	int n_errors    = 0;
	int burst_left  = 0;
	int idle_cycles = 0;
	int status_seen [8];

	arp_cache_table #(.ENTRIES(CACHE_SLOTS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.ip_address (ip_address),
		.mac_address(mac_address),
		.port_index (port_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.found_mac  (found_mac),
		.found_port (found_port),
		.status     (status)
	);

	always #1 clk = ~clk;

	function automatic int find_entry(input logic [31:0] ip);
		for (int i = 0; i < CACHE_SLOTS; i++)
			if (tbl_valid[i] && tbl_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic arpc_pkg::result_t predict_arp(input logic [1:0] op,
			input logic [31:0] ip, input logic [47:0] mac, input logic [3:0] port);
		arpc_pkg::result_t r;
		int hit;
		int free_idx;
		r = '0;
		r.status = arpc_pkg::ST_MISS;
		hit = find_entry(ip);
		case (op)
			arpc_pkg::MODE_LOOKUP: begin
				if (hit >= 0) begin
					r.found  = 1'b1;
					r.mac    = tbl_mac[hit];
					r.port   = tbl_port[hit];
					r.status = arpc_pkg::ST_HIT;
				end
			end
			arpc_pkg::MODE_LEARN: begin
				if (port < arpc_pkg::PORTS) begin
					if (hit >= 0) begin
						if (tbl_mac[hit] == mac && tbl_port[hit] == port) begin
							r.status = arpc_pkg::ST_UNCHANGED;
						end else begin
							tbl_mac[hit]  = mac;
							tbl_port[hit] = port;
							r.status      = arpc_pkg::ST_REPLACED;
						end
					end else begin
						free_idx = -1;
						for (int i = CACHE_SLOTS - 1; i >= 0; i--)
							if (!tbl_valid[i])
								free_idx = i;
						if (free_idx >= 0) begin
							tbl_valid[free_idx] = 1'b1;
							tbl_ip[free_idx]    = ip;
							tbl_mac[free_idx]   = mac;
							tbl_port[free_idx]  = port;
							r.status            = arpc_pkg::ST_ADDED;
						end else begin
							r.status = arpc_pkg::ST_FULL;
						end
					end
				end
			end
			arpc_pkg::MODE_DELETE: begin
				if (hit >= 0) begin
					tbl_valid[hit] = 1'b0;
					r.status       = arpc_pkg::ST_DELETED;
				end
			end
			default: begin
				for (int i = 0; i < CACHE_SLOTS; i++)
					tbl_valid[i] = 1'b0;
				r.status = arpc_pkg::ST_CLEARED;
			end
		endcase
		return r;
	endfunction

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic logic [31:0] fresh_key();
		logic [31:0] k;
		do
			k = $urandom;
		while (find_entry(k) >= 0);
		return k;
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// called at a rising edge; returns at the edge where the request was taken
	task automatic send_request(input logic [1:0] op, input logic [31:0] ip,
			input logic [47:0] mac, input logic [3:0] port);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		mode        <= op;
		ip_address  <= ip;
		mac_address <= mac;
		port_index  <= port;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_arp(op, ip, mac, port));
		status_seen[pending_results[$].status]++;
		n_requests++;
		burst_left--;
	endtask

	task automatic test_drain_pause();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
		burst_left = 0;
	endtask

	task automatic test_directed();
		send_request(arpc_pkg::MODE_LOOKUP, 32'h0000_0000, rand_mac(), 4'hF);
		send_request(arpc_pkg::MODE_DELETE, 32'hFFFF_FFFF, rand_mac(), 4'h0);
		send_request(arpc_pkg::MODE_CLEAR,  32'h1234_5678, rand_mac(), 4'h9);
		send_request(arpc_pkg::MODE_LEARN,  32'h0000_0000, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
		send_request(arpc_pkg::MODE_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 4'hF);
		send_request(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LOOKUP, 32'h0000_0001, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
		send_request(arpc_pkg::MODE_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hE);
		send_request(arpc_pkg::MODE_LEARN,  32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFE, 4'hE);
		send_request(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_DELETE, 32'h0000_0000, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LOOKUP, 32'h0000_0000, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_DELETE, 32'h0000_0000, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LEARN,  32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 4'h5);
		send_request(arpc_pkg::MODE_LOOKUP, 32'hA5A5_A5A5, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_CLEAR,  32'hA5A5_A5A5, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 4'h0);
		send_request(arpc_pkg::MODE_LOOKUP, 32'hA5A5_A5A5, 48'h0, 4'h0);
	endtask

	task automatic test_table_full();
		logic [31:0] ip;
		int slot;
		send_request(arpc_pkg::MODE_CLEAR, $urandom, rand_mac(),
			4'($urandom_range(0, 15)));
		repeat (CACHE_SLOTS)
			send_request(arpc_pkg::MODE_LEARN, fresh_key(), rand_mac(),
				4'($urandom_range(0, 15)));
		ip = fresh_key();
		send_request(arpc_pkg::MODE_LEARN, ip, rand_mac(), 4'($urandom_range(0, 15)));
		send_request(arpc_pkg::MODE_LOOKUP, ip, rand_mac(), 4'($urandom_range(0, 15)));
		slot = $urandom_range(0, CACHE_SLOTS - 1);
		send_request(arpc_pkg::MODE_DELETE, tbl_ip[slot], rand_mac(),
			4'($urandom_range(0, 15)));
		send_request(arpc_pkg::MODE_LEARN, ip, rand_mac(), 4'($urandom_range(0, 15)));
		send_request(arpc_pkg::MODE_LEARN, fresh_key(), rand_mac(),
			4'($urandom_range(0, 15)));
		for (int i = 0; i < CACHE_SLOTS; i++)
			send_request(arpc_pkg::MODE_LOOKUP, tbl_ip[i], rand_mac(),
				4'($urandom_range(0, 15)));
	endtask

	task automatic test_random_traffic(input int n_items, input int pool_size);
		logic [1:0]  op;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [3:0]  port;
		int sel;
		int slot;
		int b;
		key_pool.delete();
		key_pool.push_back(32'h0000_0000);
		key_pool.push_back(32'hFFFF_FFFF);
		while (key_pool.size() < pool_size) begin
			if ($urandom_range(0, 3) == 0)
				key_pool.push_back(key_pool[$] ^ (32'h1 << $urandom_range(0, 31)));
			else
				key_pool.push_back($urandom);
		end
		repeat (n_items) begin
			sel  = $urandom_range(0, 99);
			ip   = key_pool[$urandom_range(0, key_pool.size() - 1)];
			mac  = rand_mac();
			port = 4'($urandom_range(0, 15));
			if (sel < 35) begin
				op = arpc_pkg::MODE_LOOKUP;
			end else if (sel < 75) begin
				op = arpc_pkg::MODE_LEARN;
				slot = $urandom_range(0, CACHE_SLOTS - 1);
				if (sel < 55 && tbl_valid[slot]) begin
					ip   = tbl_ip[slot];
					mac  = tbl_mac[slot];
					port = tbl_port[slot];
					b    = $urandom_range(0, 47);
					case ($urandom_range(0, 2))
						1: mac[b] = ~mac[b];
						2: port   = port + 4'd1;
						default: ;
					endcase
				end
			end else if (sel < 95) begin
				op = arpc_pkg::MODE_DELETE;
			end else if (sel < 97) begin
				op = arpc_pkg::MODE_CLEAR;
			end else begin
				op = 2'($urandom_range(0, 3));
				ip = $urandom;
			end
			send_request(op, ip, mac, port);
		end
	endtask

	always @(posedge clk) begin
		arpc_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no request pending (status %0d)", status));
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found)
					report_mismatch($sformatf("found %b, expected %b", found, want.found));
				if (found_mac !== want.mac)
					report_mismatch($sformatf("found_mac %h, expected %h", found_mac, want.mac));
				if (found_port !== want.port)
					report_mismatch($sformatf("found_port %0d, expected %0d",
						found_port, want.port));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
			end
		end
	end

	initial begin
		int style;
		int seg_len;
		int run_len;
		logic lvl;
		run_len = 0;
		lvl     = 1'b0;
		forever begin
			style   = $urandom_range(0, 3);
			seg_len = $urandom_range(20, 200);
			repeat (seg_len) begin
				@(posedge clk);
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: begin
						if (run_len == 0) begin
							lvl     = ~lvl;
							run_len = $urandom_range(1, 30);
						end
						run_len--;
						out_stall <= lvl;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(600, 12);
		test_drain_pause();
		test_table_full();
		test_random_traffic(650, 40);
		test_table_full();
		test_drain_pause();
		repeat (40) @(posedge clk);
		$display("Ran %0d requests, checked %0d results, %0d mismatches", n_requests,
			n_results, n_errors);
		$display("Statuses hit/miss/add/same/repl/del/full/clr: %0d %0d %0d %0d %0d %0d %0d %0d",
			status_seen[arpc_pkg::ST_HIT], status_seen[arpc_pkg::ST_MISS],
			status_seen[arpc_pkg::ST_ADDED], status_seen[arpc_pkg::ST_UNCHANGED],
			status_seen[arpc_pkg::ST_REPLACED], status_seen[arpc_pkg::ST_DELETED],
			status_seen[arpc_pkg::ST_FULL], status_seen[arpc_pkg::ST_CLEARED]);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
